// ----- sv/dhh_pkg.sv -----
// ----------------------------------------------------------------------------
// dhh_pkg
// shared constants, codes, types and helper functions of the hexamer
// histogram core
// ----------------------------------------------------------------------------
package dhh_pkg;

   localparam int BLOCK_LENGTH    = 6;
   localparam int BLOCKS_PER_LINE = 10;
   localparam int LINE_CHARS      = BLOCK_LENGTH * BLOCKS_PER_LINE;
   localparam int BIN_BITS        = 2 * BLOCK_LENGTH;
   localparam int TABLE_SIZE      = 4096;
   localparam int ADDR_BITS       = $clog2(TABLE_SIZE);
   localparam int COUNT_BITS      = 32;
   localparam int LEN_BITS        = $clog2(LINE_CHARS + 2);
   localparam int POS_BITS        = $clog2(BLOCK_LENGTH);
   localparam int BLK_IDX_BITS    = $clog2(BLOCKS_PER_LINE + 1);

   // request modes
   localparam logic [1:0] MODE_CHAR = 2'd0;
   localparam logic [1:0] MODE_EOL  = 2'd1;
   localparam logic [1:0] MODE_READ = 2'd2;

   // response status codes
   localparam logic [2:0] STATUS_TAKEN     = 3'd0;
   localparam logic [2:0] STATUS_COUNTED   = 3'd1;
   localparam logic [2:0] STATUS_SKIPPED   = 3'd2;
   localparam logic [2:0] STATUS_BAD_CHAR  = 3'd3;
   localparam logic [2:0] STATUS_HALTED    = 3'd4;
   localparam logic [2:0] STATUS_READ_DATA = 3'd5;

   // ascii letters
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;

   // storage letter codes
   localparam logic [1:0] NUC_A = 2'd0;
   localparam logic [1:0] NUC_T = 2'd1;
   localparam logic [1:0] NUC_C = 2'd2;
   localparam logic [1:0] NUC_G = 2'd3;

   // rank digits, alphabetical order
   localparam logic [1:0] RANK_A = 2'd0;
   localparam logic [1:0] RANK_C = 2'd1;
   localparam logic [1:0] RANK_G = 2'd2;
   localparam logic [1:0] RANK_T = 2'd3;

   typedef logic [BIN_BITS-1:0]   bin_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [BLOCKS_PER_LINE-1:0][BIN_BITS-1:0] line_blocks_type;

   typedef struct packed {
      logic                 walk_start;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic      busy;
      logic      rd_valid;
      count_type rd_count;
   } store_stat_type;

   // letter byte to 2-bit storage code, bad letters code as A
   function automatic logic [1:0] nuc_code(input logic [7:0] ch);
      logic [1:0] code;
      case (ch)
         CHAR_A:  code = NUC_A;
         CHAR_T:  code = NUC_T;
         CHAR_C:  code = NUC_C;
         CHAR_G:  code = NUC_G;
         default: code = NUC_A;
      endcase
      return code;
   endfunction

   function automatic logic nuc_bad(input logic [7:0] ch);
      logic bad;
      case (ch)
         CHAR_A, CHAR_T, CHAR_C, CHAR_G: bad = 1'b0;
         default:                        bad = 1'b1;
      endcase
      return bad;
   endfunction

   // alphabetical rank to storage bin, one digit per letter
   function automatic bin_type rank_to_code(input bin_type rank);
      bin_type    code;
      logic [1:0] digit;
      logic [1:0] nuc;
      code = '0;
      for (int k = 0; k < BLOCK_LENGTH; k++) begin
         digit = rank[2*(BLOCK_LENGTH-1-k) +: 2];
         case (digit)
            RANK_A:  nuc = NUC_A;
            RANK_C:  nuc = NUC_C;
            RANK_G:  nuc = NUC_G;
            RANK_T:  nuc = NUC_T;
            default: nuc = NUC_A;
         endcase
         code = {code[BIN_BITS-3:0], nuc};
      end
      return code;
   endfunction

endpackage

// ----- sv/dhh_bin_store.sv -----
// ----------------------------------------------------------------------------
// dhh_bin_store
// bin count memory with clearing pass, line-end increment walk and reads
// ----------------------------------------------------------------------------
module dhh_bin_store (
   input  logic                     clock,
   input  logic                     reset,
   input  dhh_pkg::store_cmd_type   cmd,
   input  dhh_pkg::line_blocks_type line_blocks,
   output dhh_pkg::store_stat_type  stat
);
   import dhh_pkg::*;

   count_type bin_mem [TABLE_SIZE];

   logic                    clearing_ff, clearing_in;
   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic                    walking_ff, walking_in;
   logic [BLK_IDX_BITS-1:0] walk_idx_ff, walk_idx_in;
   logic                    wb_valid_ff, wb_valid_in;
   logic [ADDR_BITS-1:0]    wb_addr_ff;
   logic                    fwd_valid_ff;
   logic [ADDR_BITS-1:0]    fwd_addr_ff;
   count_type               fwd_data_ff;
   logic                    rd_valid_ff;
   count_type               rd_data_ff;

   logic [ADDR_BITS-1:0] rd_addr;
   count_type            old_count;
   count_type            new_count;
   logic                 walk_last;

   assign walk_last = (walk_idx_ff == BLK_IDX_BITS'(BLOCKS_PER_LINE - 1));
   assign rd_addr   = walking_ff ? line_blocks[walk_idx_ff][ADDR_BITS-1:0] : cmd.rd_addr;

   // a bin written last cycle is still stale in the read data
   assign old_count = (fwd_valid_ff && (fwd_addr_ff == wb_addr_ff)) ? fwd_data_ff : rd_data_ff;
   assign new_count = (old_count == '1) ? old_count : old_count + 1'b1;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      walking_in  = walking_ff;
      walk_idx_in = walk_idx_ff;
      wb_valid_in = walking_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end
      if (walking_ff) begin
         walk_idx_in = walk_idx_ff + 1'b1;
         if (walk_last) begin
            walking_in = 1'b0;
         end
      end else if (cmd.walk_start) begin
         walking_in  = 1'b1;
         walk_idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         walking_ff   <= 1'b0;
         walk_idx_ff  <= '0;
         wb_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         walking_ff   <= walking_in;
         walk_idx_ff  <= walk_idx_in;
         wb_valid_ff  <= wb_valid_in;
         fwd_valid_ff <= wb_valid_ff;
         rd_valid_ff  <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff  <= rd_addr;
      fwd_addr_ff <= wb_addr_ff;
      fwd_data_ff <= new_count;
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         bin_mem[clr_addr_ff] <= '0;
      end else if (wb_valid_ff) begin
         bin_mem[wb_addr_ff] <= new_count;
      end
      rd_data_ff <= bin_mem[rd_addr];
   end

   assign stat.busy     = clearing_ff | walking_ff | wb_valid_ff;
   assign stat.rd_valid = rd_valid_ff;
   assign stat.rd_count = rd_data_ff;

endmodule

// ----- sv/dna_hexamer_histogram_core.sv -----
// ----------------------------------------------------------------------------
// dna_hexamer_histogram_core
// counts the 6-letter blocks of 60-letter dna lines in a 4096-bin histogram
// ----------------------------------------------------------------------------
// A character word (mode 0) holds no req_stall of its own. A bin read (mode 2)
// holds req_stall while the memory read completes, and its answer passes the
// read data register of the store and then the response register.
// An end-of-line word that counts a line holds req_stall while the ten bin
// increments run one per cycle through the read port of the single bin
// memory, with a registered write-back and forwarding for repeated bins.
// Other end-of-line words hold no req_stall of their own. After reset the
// core runs a clearing pass over all 4096 bins and takes no word until
// it is done. Each word gives exactly one response word; while a response
// word waits on rsp_stall the core holds req_stall, so a new word is taken
// at the earliest in the cycle the waiting response is taken.
// ----------------------------------------------------------------------------
module dna_hexamer_histogram_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_symbol,
   input  logic [11:0] req_rank,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [11:0] rsp_block_code,
   output logic [31:0] rsp_count,
   output logic        rsp_present
);
   import dhh_pkg::*;

   // line assembly state
   bin_type                 partial_ff, partial_in;
   logic [LEN_BITS-1:0]     len_ff, len_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [BLK_IDX_BITS-1:0] blk_idx_ff, blk_idx_in;
   logic                    bad_ff, bad_in;
   logic                    fatal_ff, fatal_in;
   line_blocks_type         blocks_ff, blocks_in;

   // read in flight
   logic                    pend_read_ff, pend_read_in;
   bin_type                 pend_code_ff, pend_code_in;

   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   bin_type                 rsp_code_ff, rsp_code_in;
   count_type               rsp_count_ff, rsp_count_in;
   logic                    rsp_present_ff, rsp_present_in;

   store_cmd_type           cmd;
   store_stat_type          stat;

   logic                    accept;
   logic                    load_direct;
   logic [2:0]              direct_status;
   logic [1:0]              sym_code;
   logic                    sym_bad;
   bin_type                 partial_shift;
   bin_type                 rank_code;

   // stall while the store is busy, a read is in flight or the response is held
   assign req_stall = stat.busy | pend_read_ff | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   assign sym_code      = nuc_code(req_symbol);
   assign sym_bad       = nuc_bad(req_symbol);
   assign partial_shift = {partial_ff[BIN_BITS-3:0], sym_code};
   assign rank_code     = rank_to_code(req_rank);

   // request decode and line assembly
   always_comb begin
      partial_in     = partial_ff;
      len_in         = len_ff;
      pos_in         = pos_ff;
      blk_idx_in     = blk_idx_ff;
      bad_in         = bad_ff;
      fatal_in       = fatal_ff;
      blocks_in      = blocks_ff;
      pend_read_in   = pend_read_ff;
      pend_code_in   = pend_code_ff;
      direct_status  = STATUS_TAKEN;
      load_direct    = 1'b0;
      cmd.walk_start = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.rd_addr    = rank_code[ADDR_BITS-1:0];

      // read data returned, pending read done
      if (stat.rd_valid) begin
         pend_read_in = 1'b0;
      end

      if (accept) begin
         case (req_mode)
            MODE_CHAR: begin
               load_direct = 1'b1;
               if (fatal_ff) begin
                  direct_status = STATUS_HALTED;
               end else begin
                  bad_in = bad_ff | sym_bad;
                  // letters past the line length only bump the length and the bad flag
                  if (len_ff < LEN_BITS'(LINE_CHARS)) begin
                     if (pos_ff == POS_BITS'(BLOCK_LENGTH - 1)) begin
                        blocks_in[blk_idx_ff] = partial_shift;
                        partial_in            = '0;
                        pos_in                = '0;
                        blk_idx_in            = blk_idx_ff + 1'b1;
                     end else begin
                        partial_in = partial_shift;
                        pos_in     = pos_ff + 1'b1;
                     end
                  end
                  if (len_ff < LEN_BITS'(LINE_CHARS + 1)) begin
                     len_in = len_ff + 1'b1;
                  end
               end
            end
            MODE_EOL: begin
               load_direct = 1'b1;
               if (fatal_ff) begin
                  direct_status = STATUS_HALTED;
               end else if (len_ff != LEN_BITS'(LINE_CHARS)) begin
                  direct_status = STATUS_SKIPPED;
               end else if (bad_ff) begin
                  fatal_in      = 1'b1;
                  direct_status = STATUS_BAD_CHAR;
               end else begin
                  cmd.walk_start = 1'b1;
                  direct_status  = STATUS_COUNTED;
               end
               // every end of line starts a fresh line
               partial_in = '0;
               len_in     = '0;
               pos_in     = '0;
               blk_idx_in = '0;
               bad_in     = 1'b0;
            end
            MODE_READ: begin
               cmd.rd_en    = 1'b1;
               pend_read_in = 1'b1;
               pend_code_in = rank_code;
            end
            default: begin
               load_direct   = 1'b1;
               direct_status = STATUS_TAKEN;
            end
         endcase
      end
   end

   // response register, loaded directly or from returned read data
   always_comb begin
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_code_in    = rsp_code_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_present_in = rsp_present_ff;
      if (load_direct) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = direct_status;
         rsp_code_in    = '0;
         rsp_count_in   = '0;
         rsp_present_in = 1'b0;
      end else if (stat.rd_valid) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STATUS_READ_DATA;
         rsp_code_in    = pend_code_ff;
         rsp_count_in   = stat.rd_count;
         rsp_present_in = |stat.rd_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         blk_idx_ff   <= '0;
         bad_ff       <= 1'b0;
         fatal_ff     <= 1'b0;
         pend_read_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         blk_idx_ff   <= blk_idx_in;
         bad_ff       <= bad_in;
         fatal_ff     <= fatal_in;
         pend_read_ff <= pend_read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      blocks_ff      <= blocks_in;
      pend_code_ff   <= pend_code_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_code_ff    <= rsp_code_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_present_ff <= rsp_present_in;
   end

   dhh_bin_store u_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .line_blocks (blocks_ff),
      .stat        (stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_block_code = rsp_code_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_present    = rsp_present_ff;

`ifndef SYNTHESIS
   // read data lands only in an empty response register
   assert property (@(posedge clock) disable iff (reset) stat.rd_valid |-> !rsp_valid_ff)
      else $error("read data would overwrite a held response");

   // a pending read gets its read data in the same cycle
   assert property (@(posedge clock) disable iff (reset) pend_read_ff |-> stat.rd_valid)
      else $error("pending read got no data");

   // fatal error is sticky
   assert property (@(posedge clock) disable iff (reset) fatal_ff |=> fatal_ff)
      else $error("fatal error cleared");

   // line length saturates one past the full line
   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_BITS'(LINE_CHARS + 1))
      else $error("line length out of range");
`endif

endmodule

// ----- tb/dna_hexamer_histogram_core_tb.sv -----
// ----------------------------------------------------------------------------
// dna_hexamer_histogram_core_tb
// directed and random test of the hexamer histogram core: a scoreboard keeps
// its own copy of the line, block and bin state, predicts every response word
// and checks the responses in order while both channels idle at random
// ----------------------------------------------------------------------------
module dna_hexamer_histogram_core_tb;
   import dhh_pkg::*;

   // the spare mode, ignored by the core
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam int CLOCK_HALF     = 10;
   localparam int RANDOM_WORDS   = 1900;
   localparam int HOLDOFF_AT     = 400;   // words taken before the long hold-off
   localparam int HOLDOFF_CYCLES = 300;
   localparam int DRAIN_CYCLES   = 24;    // covers the longest end-of-line hold plus a read
   localparam int RUN_LIMIT      = 4_000_000;

   typedef enum int {SHAPE_RANDOM, SHAPE_REPEAT, SHAPE_FEW, SHAPE_AT} line_shape_type;

   typedef struct packed {
      logic [2:0] status;
      bin_type    block_code;
      count_type  count;
      logic       present;
   } answer_type;

   // keeps the histogram state and the queue of response words still due
   class hist_scoreboard;
      count_type  tally [TABLE_SIZE];
      bin_type    line_blocks [BLOCKS_PER_LINE];
      bin_type    partial;
      int         line_len;
      bit         line_marked;
      bit         halted;
      answer_type answers_due [$];
      bin_type    recent_slots [$];
      int         words_taken;
      int         errors;

      function new();
         foreach (tally[i]) tally[i] = '0;
         foreach (line_blocks[i]) line_blocks[i] = '0;
         partial     = '0;
         line_len    = 0;
         line_marked = 1'b0;
         halted      = 1'b0;
         words_taken = 0;
         errors      = 0;
      endfunction

      function logic [2:0] take_char(logic [7:0] symbol);
         logic [1:0] letter;
         letter = NUC_A;
         if (halted) return STATUS_HALTED;
         case (symbol)
            CHAR_A:  letter = NUC_A;
            CHAR_T:  letter = NUC_T;
            CHAR_C:  letter = NUC_C;
            CHAR_G:  letter = NUC_G;
            default: line_marked = 1'b1;
         endcase
         // letters past the line length only move the length counter and the bad mark
         if (line_len < LINE_CHARS) begin
            partial = {partial[BIN_BITS-3:0], letter};
            if ((line_len + 1) % BLOCK_LENGTH == 0) begin
               line_blocks[line_len / BLOCK_LENGTH] = partial;
               partial = '0;
            end
         end
         if (line_len <= LINE_CHARS) line_len++;
         return STATUS_TAKEN;
      endfunction

      function logic [2:0] close_line();
         logic [2:0] st;
         if (halted) begin
            st = STATUS_HALTED;
         end else if (line_len != LINE_CHARS) begin
            st = STATUS_SKIPPED;
         end else if (line_marked) begin
            halted = 1'b1;
            st = STATUS_BAD_CHAR;
         end else begin
            foreach (line_blocks[i]) begin
               if (tally[line_blocks[i]] != '1) tally[line_blocks[i]] += 1;
               recent_slots = {recent_slots, line_blocks[i]};
            end
            while (recent_slots.size() > 40) void'(recent_slots.pop_front());
            st = STATUS_COUNTED;
         end
         partial     = '0;
         line_len    = 0;
         line_marked = 1'b0;
         return st;
      endfunction

      function answer_type read_rank(logic [11:0] rank);
         answer_type a;
         bin_type    slot;
         logic [1:0] letter;
         slot = '0;
         for (int k = BLOCK_LENGTH - 1; k >= 0; k--) begin
            case (rank[2*k +: 2])
               RANK_A:  letter = NUC_A;
               RANK_C:  letter = NUC_C;
               RANK_G:  letter = NUC_G;
               default: letter = NUC_T;
            endcase
            slot = {slot[BIN_BITS-3:0], letter};
         end
         a.status     = STATUS_READ_DATA;
         a.block_code = slot;
         a.count      = tally[slot];
         a.present    = (tally[slot] != '0);
         return a;
      endfunction

      // rank of a recently counted bin, so that reads mostly hit live counts
      function logic [11:0] pick_rank();
         logic [11:0] r;
         bin_type     slot;
         if (recent_slots.size() == 0 || $urandom_range(0, 3) == 0)
            return 12'($urandom_range(0, 4095));
         slot = recent_slots[$urandom_range(0, recent_slots.size() - 1)];
         for (int k = 0; k < BLOCK_LENGTH; k++) begin
            case (slot[2*k +: 2])
               NUC_A:   r[2*k +: 2] = RANK_A;
               NUC_T:   r[2*k +: 2] = RANK_T;
               NUC_C:   r[2*k +: 2] = RANK_C;
               default: r[2*k +: 2] = RANK_G;
            endcase
         end
         return r;
      endfunction

      function void note_word(logic [1:0] mode, logic [7:0] symbol, logic [11:0] rank);
         answer_type a;
         a = '0;
         words_taken++;
         case (mode)
            MODE_CHAR: a.status = take_char(symbol);
            MODE_EOL:  a.status = close_line();
            MODE_READ: a = read_rank(rank);
            default:   a.status = STATUS_TAKEN;
         endcase
         answers_due = {answers_due, a};
      endfunction

      function void check_answer(logic [2:0] status, logic [11:0] block_code,
                                 logic [31:0] count, logic present);
         answer_type want;
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: response word with none due: status %0d code %h count %0d",
                     $time, status, block_code, count);
            return;
         end
         want = answers_due.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
         if (block_code !== want.block_code) begin
            errors++;
            $display("%0t: block_code expected %h actual %h", $time, want.block_code,
                     block_code);
         end
         if (count !== want.count) begin
            errors++;
            $display("%0t: count expected %0d actual %0d", $time, want.count, count);
         end
         if (present !== want.present) begin
            errors++;
            $display("%0t: present expected %0d actual %0d", $time, want.present, present);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_valid  = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode   = MODE_CHAR;
   logic [7:0]  req_symbol = 8'h00;
   logic [11:0] req_rank   = 12'h000;
   logic        rsp_valid;
   logic        rsp_stall  = 1'b0;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_block_code;
   logic [31:0] rsp_count;
   logic        rsp_present;

   hist_scoreboard sb = new();
   int burst_left = 0;

   dna_hexamer_histogram_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_symbol     (req_symbol),
      .req_rank       (req_rank),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_block_code (rsp_block_code),
      .rsp_count      (rsp_count),
      .rsp_present    (rsp_present)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // after a word is taken the sender either carries on in its burst or drops
   // valid for a random gap, which may be zero, and then starts a new burst
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
   endtask

   // offers one word and holds it until the core takes it
   task automatic send_word(input logic [1:0] mode, input logic [7:0] symbol,
                            input logic [11:0] rank);
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_symbol <= symbol;
      req_rank   <= rank;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_word(mode, symbol, rank);
      pace_sender();
   endtask

   // the unused field of every word carries random bits
   task automatic send_char(input logic [7:0] symbol);
      send_word(MODE_CHAR, symbol, 12'($urandom_range(0, 4095)));
   endtask

   task automatic send_eol();
      send_word(MODE_EOL, 8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)));
   endtask

   task automatic send_read(input logic [11:0] rank);
      send_word(MODE_READ, 8'($urandom_range(0, 255)), rank);
   endtask

   function automatic logic [7:0] random_letter();
      case ($urandom_range(0, 3))
         0:       return CHAR_A;
         1:       return CHAR_T;
         2:       return CHAR_C;
         default: return CHAR_G;
      endcase
   endfunction

   function automatic logic [7:0] bad_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_A || b == CHAR_T || b == CHAR_C || b == CHAR_G);
      return b;
   endfunction

   // words that leave the line state alone: reads and the spare mode
   task automatic send_noise();
      case ($urandom_range(0, 3))
         0, 1:    send_read(sb.pick_rank());
         2:       send_read(12'($urandom_range(0, 4095)));
         default: send_word(MODE_SPARE, 8'($urandom_range(0, 255)),
                            12'($urandom_range(0, 4095)));
      endcase
   endtask

   // letters of one line, without its end mark; a bad byte goes at bad_at
   task automatic send_line(input int length, input line_shape_type shape, input int bad_at);
      logic [7:0] motif [3][BLOCK_LENGTH];
      logic [7:0] ch;
      int         pick;
      pick = 0;
      for (int m = 0; m < 3; m++)
         for (int j = 0; j < BLOCK_LENGTH; j++)
            motif[m][j] = random_letter();
      for (int n = 0; n < length; n++) begin
         case (shape)
            // one block ten times over: back-to-back increments of one bin
            SHAPE_REPEAT: ch = motif[0][n % BLOCK_LENGTH];
            // three blocks mixed: repeats both adjacent and spread out
            SHAPE_FEW: begin
               if (n % BLOCK_LENGTH == 0) pick = $urandom_range(0, 2);
               ch = motif[pick][n % BLOCK_LENGTH];
            end
            SHAPE_AT:     ch = $urandom_range(0, 1) ? CHAR_A : CHAR_T;
            default:      ch = random_letter();
         endcase
         if (n == bad_at) ch = bad_byte();
         send_char(ch);
         if ($urandom_range(0, 39) == 0) send_noise();
      end
   endtask

   // stimulus and end of run
   initial begin : stimulus
      int             roll;
      int             len;
      line_shape_type shape;
      roll  = 0;
      len   = 0;
      shape = SHAPE_RANDOM;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty store reads at both ends of the rank range, the spare mode
      send_read(12'h000);
      send_read(12'hfff);
      send_word(MODE_SPARE, 8'hff, 12'hfff);
      // end mark of an empty line
      send_eol();
      // bad bytes in a short line only get it skipped
      send_char(8'h00);
      send_char(8'hff);
      send_char(8'h61);
      send_char(CHAR_A);
      send_eol();
      // all-A and all-G lines: ten hits on bin 0 and on the top bin
      repeat (LINE_CHARS) send_char(CHAR_A);
      send_eol();
      repeat (LINE_CHARS) send_char(CHAR_G);
      send_eol();
      send_read(12'h000);
      send_read(12'haaa);
      send_read(12'hfff);

      // random part: mostly full lines with varied content, some broken lines
      while (sb.words_taken < RANDOM_WORDS) begin
         roll  = $urandom_range(0, 99);
         shape = line_shape_type'($urandom_range(0, 3));
         if (roll < 65) begin
            send_line(LINE_CHARS, shape, -1);
            send_eol();
            repeat ($urandom_range(0, 2)) send_read(sb.pick_rank());
         end else if (roll < 73) begin
            len = $urandom_range(0, LINE_CHARS - 1);
            send_line(len, shape,
                      (len > 0 && $urandom_range(0, 1)) ? $urandom_range(0, len - 1) : -1);
            send_eol();
         end else if (roll < 81) begin
            // too long, possibly with a bad byte before or past the sixtieth
            len = $urandom_range(LINE_CHARS + 1, LINE_CHARS + 8);
            send_line(len, shape, $urandom_range(0, 1) ? $urandom_range(0, len - 1) : -1);
            send_eol();
         end else if (roll < 86) begin
            send_eol();
         end else begin
            repeat ($urandom_range(1, 6)) send_noise();
         end
      end

      // a bad byte in a full-length line halts counting for good
      send_line(LINE_CHARS, SHAPE_RANDOM, $urandom_range(0, LINE_CHARS - 1));
      send_eol();
      send_char(CHAR_G);
      send_char(bad_byte());
      send_eol();
      send_line(LINE_CHARS, SHAPE_RANDOM, -1);
      send_eol();
      // reads still answer while halted
      send_read(sb.pick_rank());
      send_read(12'h000);
      req_valid <= 1'b0;

      while (sb.answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("dna_hexamer_histogram_core_tb: done, clean");
      else
         $display("dna_hexamer_histogram_core_tb: done, errors");
      $finish;
   end

   // response side: checks every word taken and stalls on its own pattern,
   // including one long hold-off that backs the core up into req_stall
   initial begin : receiver
      int tick;
      int holdoff_left;
      bit holdoff_done;
      int stall_style;
      tick         = 0;
      holdoff_left = 0;
      holdoff_done = 1'b0;
      stall_style  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_answer(rsp_status, rsp_block_code, rsp_count, rsp_present);
         tick++;
         if (tick % 150 == 0) stall_style = $urandom_range(0, 3);
         if (!holdoff_done && sb.words_taken >= HOLDOFF_AT) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((tick % 5) < 2);
            endcase
         end
      end
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #RUN_LIMIT;
      $display("dna_hexamer_histogram_core_tb: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/dhh_pkg.sv
sv/dhh_bin_store.sv
sv/dna_hexamer_histogram_core.sv
tb/dna_hexamer_histogram_core_tb.sv
